/* hdl/first_fit_heap_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Shared assertion forms clocked on clk; all but FFHA_ASSERT_RST are off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffha assertion failed");

// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffha assertion failed");

// Next-cycle implication, checked during reset as well.
`define FFHA_ASSERT_RST(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
		else $error("ffha assertion failed");

`endif

/* hdl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Constants, operation and status codes, controller states and store control type.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 16;

	localparam int REQ_W    = 12;
	localparam int OFF_W    = 12;
	localparam int GRANT_W  = 13;
	localparam int STATUS_W = 2;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE     = 2'd0,
		STAT_NO_SPACE = 2'd1,
		STAT_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_FREE,
		S_READ,
		S_EVAL,
		S_CMP,
		S_SPLIT,
		S_WSPLIT,
		S_LINK,
		S_SIZE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic size_we;
		logic link_we;
	} store_ctl_t;

endpackage

/* hdl/first_fit_heap_allocator_top.sv */
// A free runs S_FREE, S_DONE. An allocate runs S_READ, S_EVAL, S_CMP per block,
// then S_SPLIT, S_WSPLIT if it splits, S_LINK, S_SIZE, S_DONE; if none fits, S_DONE.
// One item is in work at a time; the walk is bound by one store read per block.
// A finished result waits in an output register while the next item is taken.
// Reset clears the controller; the first cycle after reset writes the header at
// offset 0 (whole heap free), and no transfer is taken in that cycle.
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Free-list heap manager with a sequencer around one shared adder.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // request_bytes[11:0], release_offset[23:12]
	input  logic [0:0]  s_tuser,  // op[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // payload_offset[11:0], granted_bytes[24:12], zero
	output logic [1:0]  m_tuser   // status[1:0]
);
	import ffha_pkg::*;

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int SW = AW + 1;
	localparam int CW = (SW > GRANT_W) ? SW : GRANT_W;
	localparam logic [SW-1:0] LINK_END = SW'(HEAP_BYTES);
	localparam logic [SW-1:0] POS_LIM  = SW'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [CW-1:0] HDR_C    = CW'(HEADER_BYTES);
	localparam logic [CW-1:0] HEAP_C   = CW'(HEAP_BYTES);

	state_t state_q, state_d;

	logic [SW-1:0]      free_head_q;
	logic [OFF_W-1:0]   rel_q;
	logic [CW-1:0]      need_q;
	logic [SW-1:0]      cur_q, prev_q, nxt_q, size_q, rest_q, target_q, granted_q;
	logic [SW-1:0]      steps_q;
	logic               pos_ok_q;
	status_t            status_q;
	logic [OFF_W-1:0]   off_q;
	logic [GRANT_W-1:0] grant_q;

	logic               m_valid_q;
	status_t            m_status_q;
	logic [OFF_W-1:0]   m_off_q;
	logic [GRANT_W-1:0] m_grant_q;

	logic [CW-1:0] alu_a, alu_b;
	logic          alu_sub;
	logic [CW:0]   alu_res;
	logic          alu_borrow;

	store_ctl_t    ctl;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [SW-1:0] size_wdata, link_wdata, rd_size, rd_link;

	logic          in_xfer, out_load, walk_end, fits, do_split, bad_free;
	logic [SW-1:0] room;

	// Shared adder; in subtract mode the top bit is the borrow.
	assign alu_res    = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(CW+1){alu_sub}})
		+ {{CW{1'b0}}, alu_sub};
	assign alu_borrow = alu_res[CW];

	assign in_xfer  = s_tvalid && s_tready;
	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_tready);
	assign walk_end = (cur_q >= LINK_END) || (steps_q == LINK_END);
	assign fits     = !alu_borrow && pos_ok_q;
	assign do_split = alu_res[CW-1:0] >= HDR_C;
	assign bad_free = alu_borrow || ({{(CW-OFF_W){1'b0}}, rel_q} >= HEAP_C);
	assign room     = alu_res[SW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = (op_t'(s_tuser[0]) == OP_FREE) ? S_FREE : S_READ;
				end
			end
			S_FREE: begin
				state_d = S_DONE;
			end
			S_READ: begin
				state_d = walk_end ? S_DONE : S_EVAL;
			end
			S_EVAL: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (fits) begin
					state_d = do_split ? S_SPLIT : S_LINK;
				end else begin
					state_d = S_READ;
				end
			end
			S_SPLIT: begin
				state_d = S_WSPLIT;
			end
			S_WSPLIT: begin
				state_d = S_LINK;
			end
			S_LINK: begin
				state_d = S_SIZE;
			end
			S_SIZE: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!m_valid_q || m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		alu_a      = '0;
		alu_b      = '0;
		alu_sub    = 1'b0;
		ctl        = '0;
		rd_addr    = cur_q[AW-1:0];
		wr_addr    = cur_q[AW-1:0];
		size_wdata = granted_q;
		link_wdata = target_q;
		case (state_q)
			S_INIT: begin
				ctl.size_we = 1'b1;
				ctl.link_we = 1'b1;
				wr_addr     = '0;
				size_wdata  = LINK_END;
				link_wdata  = LINK_END;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				alu_a    = CW'(s_tdata[REQ_W-1:0]);
				alu_b    = HDR_C;
			end
			S_FREE: begin
				alu_a       = CW'(rel_q);
				alu_b       = HDR_C;
				alu_sub     = 1'b1;
				ctl.link_we = !bad_free;
				wr_addr     = alu_res[AW-1:0];
				link_wdata  = free_head_q;
			end
			S_READ: begin
				ctl.rd_en = !walk_end;
			end
			S_EVAL: begin
				alu_a   = HEAP_C;
				alu_b   = CW'(cur_q);
				alu_sub = 1'b1;
			end
			S_CMP: begin
				alu_a   = CW'(size_q);
				alu_b   = need_q;
				alu_sub = 1'b1;
			end
			S_SPLIT: begin
				alu_a = CW'(cur_q);
				alu_b = need_q;
			end
			S_WSPLIT: begin
				ctl.size_we = 1'b1;
				ctl.link_we = 1'b1;
				wr_addr     = target_q[AW-1:0];
				size_wdata  = rest_q;
				link_wdata  = nxt_q;
			end
			S_LINK: begin
				ctl.link_we = (prev_q < LINK_END);
				wr_addr     = prev_q[AW-1:0];
			end
			S_SIZE: begin
				ctl.size_we = 1'b1;
				alu_a       = CW'(cur_q);
				alu_b       = HDR_C;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			free_head_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FREE && !bad_free) begin
				free_head_q <= alu_res[SW-1:0];
			end
			if (state_q == S_LINK && prev_q >= LINK_END) begin
				free_head_q <= target_q;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					rel_q   <= s_tdata[REQ_W+OFF_W-1:REQ_W];
					need_q  <= alu_res[CW-1:0];
					cur_q   <= free_head_q;
					prev_q  <= LINK_END;
					steps_q <= '0;
				end
			end
			S_FREE: begin
				status_q <= bad_free ? STAT_BAD_FREE : STAT_DONE;
				off_q    <= '0;
				grant_q  <= '0;
			end
			S_READ: begin
				if (walk_end) begin
					status_q <= STAT_NO_SPACE;
					off_q    <= '0;
					grant_q  <= '0;
				end
			end
			S_EVAL: begin
				size_q   <= (rd_size > room) ? room : rd_size;
				nxt_q    <= rd_link;
				pos_ok_q <= cur_q < POS_LIM;
			end
			S_CMP: begin
				if (fits) begin
					rest_q <= alu_res[SW-1:0];
					if (do_split) begin
						granted_q <= need_q[SW-1:0];
					end else begin
						granted_q <= size_q;
						target_q  <= nxt_q;
					end
				end else begin
					prev_q  <= cur_q;
					cur_q   <= nxt_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			S_SPLIT: begin
				target_q <= alu_res[SW-1:0];
			end
			S_SIZE: begin
				status_q <= STAT_DONE;
				off_q    <= alu_res[OFF_W-1:0];
				grant_q  <= GRANT_W'(granted_q);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_status_q <= status_q;
			m_off_q    <= off_q;
			m_grant_q  <= grant_q;
		end
	end

	ffha_store #(
		.HEAP_BYTES(HEAP_BYTES),
		.AW        (AW),
		.SW        (SW)
	) u_store (
		.clk       (clk),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.size_wdata(size_wdata),
		.link_wdata(link_wdata),
		.rd_size   (rd_size),
		.rd_link   (rd_link)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(32-GRANT_W-OFF_W){1'b0}}, m_grant_q, m_off_q};
	assign m_tuser  = m_status_q;

endmodule

/* hdl/ffha_store.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator header store
// Block size and free-list link memories, one read and one write port each.
// ----------------------------------------------------------------------------
module ffha_store #(
	parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
	parameter int AW         = $clog2(HEAP_BYTES),
	parameter int SW         = AW + 1
) (
	input  logic                clk,
	input  ffha_pkg::store_ctl_t ctl,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  logic [SW-1:0]       size_wdata,
	input  logic [SW-1:0]       link_wdata,
	output logic [SW-1:0]       rd_size,
	output logic [SW-1:0]       rd_link
);
	import ffha_pkg::*;

	logic [SW-1:0] size_mem [HEAP_BYTES];
	logic [SW-1:0] link_mem [HEAP_BYTES];

	always_ff @(posedge clk) begin
		if (ctl.size_we) begin
			size_mem[wr_addr] <= size_wdata;
		end
		if (ctl.rd_en) begin
			rd_size <= size_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem[wr_addr] <= link_wdata;
		end
		if (ctl.rd_en) begin
			rd_link <= link_mem[rd_addr];
		end
	end

endmodule

/* hdl/ffha_checker.sv */
// ----------------------------------------------------------------------------
// First-fit heap allocator port checker
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_top_assert.svh"

module ffha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import ffha_pkg::*;

	logic in_xfer;
	logic out_fail;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_fail = m_tvalid && (m_tuser != STAT_DONE);

	// A clock edge under reset leaves the output register empty.
	`FFHA_ASSERT_RST(a_reset_empty, !arst_n, !m_tvalid)
	// The header write after reset keeps the input closed.
	`FFHA_ASSERT_IMP(a_init_closed, $rose(arst_n), !s_tready)
	// The input closes after each transfer, so no transfer follows directly.
	`FFHA_ASSERT_NEXT(a_one_item, in_xfer, !s_tready)
	// A refused allocate or an ignored free carries no offset and no size.
	`FFHA_ASSERT_IMP(a_fail_zero, out_fail, m_tdata == 32'd0)
	// A stalled result holds.
	`FFHA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
